### rtl/ptw_pkg.sv
// Shared types, codes and constants for the four-level page table walker.
// Used by every module of the walker; depends on nothing else.
`default_nettype none
package ptw_pkg;

  localparam int VaWidth    = 48;
  localparam int PaWidth    = 52;
  localparam int DataWidth  = 64;
  localparam int IndexWidth = 9;

  localparam logic OP_START = 1'b0;
  localparam logic OP_ENTRY = 1'b1;

  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] PAGE_4K = 2'd0;
  localparam logic [1:0] PAGE_2M = 2'd1;
  localparam logic [1:0] PAGE_1G = 2'd2;

  localparam logic CFG_TABLE_ROOT = 1'b0;
  localparam logic CFG_MAP_BASE   = 1'b1;

  localparam int PresentBit = 0;
  localparam int LargeBit   = 7;

  typedef enum logic [1:0] {
    LVL_PML4 = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_t;

  typedef struct packed {
    logic                 operation;
    logic [VaWidth-1:0]   virt_addr;
    logic [DataWidth-1:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic                 kind;
    logic [DataWidth-1:0] read_addr;
    logic [PaWidth-1:0]   phys_addr;
    logic                 page_fault;
    logic [1:0]           page_size;
  } out_item_t;

  typedef struct packed {
    logic               busy;
    level_t             level;
    logic [VaWidth-1:0] vaddr;
  } walk_state_t;

  typedef struct packed {
    logic [DataWidth-1:0] table_root;
    logic [DataWidth-1:0] map_base;
  } cfg_regs_t;

endpackage
`default_nettype wire

### rtl/ptw_cfg.sv
// Configuration registers of the walker: table root and map base.
// Depends on ptw_pkg.
`default_nettype none
module ptw_cfg
  import ptw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_index,
  input  wire logic [DataWidth-1:0] cfg_wdata,
  output cfg_regs_t                 regs
);

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TABLE_ROOT: regs_r.table_root <= cfg_wdata;
        CFG_MAP_BASE:   regs_r.map_base   <= cfg_wdata;
        default:        regs_r            <= regs_r;
      endcase
    end
  end

  assign regs = regs_r;

endmodule
`default_nettype wire

### rtl/ptw_step.sv
// Combinational walk step: one input item against the walk state gives the
// next state and at most one result item. Depends on ptw_pkg.
`default_nettype none
module ptw_step
  import ptw_pkg::*;
(
  input  in_item_t    item,
  input  walk_state_t state,
  input  cfg_regs_t   regs,
  output walk_state_t state_nxt,
  output logic        emit,
  output out_item_t   result
);

  localparam logic [DataWidth-1:0] FrameMask = 64'h000F_FFFF_FFFF_F000;

  logic [VaWidth-1:0]    req_va;
  level_t                req_level;
  logic [DataWidth-1:0]  req_ptr;
  logic [IndexWidth-1:0] req_index;
  logic [DataWidth-1:0]  req_addr;
  logic                  present;
  logic                  big_page;

  always_comb begin
    case (req_level)
      LVL_PML4: req_index = req_va[47:39];
      LVL_PDPT: req_index = req_va[38:30];
      LVL_PD:   req_index = req_va[29:21];
      LVL_PT:   req_index = req_va[20:12];
      default:  req_index = '0;
    endcase
  end

  assign req_addr = regs.map_base + (req_ptr & FrameMask)
                  + {{(DataWidth-IndexWidth-3){1'b0}}, req_index, 3'b000};

  assign present  = item.entry_data[PresentBit];
  assign big_page = item.entry_data[LargeBit];

  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    result    = '0;
    req_va    = state.vaddr;
    req_level = level_t'(state.level + 2'd1);
    req_ptr   = item.entry_data;

    if (item.operation == OP_START) begin
      req_va    = item.virt_addr;
      req_level = LVL_PML4;
      req_ptr   = regs.table_root;
      if (!state.busy) begin
        state_nxt.busy   = 1'b1;
        state_nxt.level  = LVL_PML4;
        state_nxt.vaddr  = item.virt_addr;
        emit             = 1'b1;
        result.kind      = KIND_REQ;
        result.read_addr = req_addr;
      end
    end else if (state.busy) begin
      emit        = 1'b1;
      result.kind = KIND_DONE;
      if (!present) begin
        state_nxt.busy    = 1'b0;
        state_nxt.level   = LVL_PML4;
        result.page_fault = 1'b1;
      end else if (state.level == LVL_PDPT && big_page) begin
        state_nxt.busy   = 1'b0;
        state_nxt.level  = LVL_PML4;
        result.phys_addr = {item.entry_data[51:30], state.vaddr[29:0]};
        result.page_size = PAGE_1G;
      end else if (state.level == LVL_PD && big_page) begin
        state_nxt.busy   = 1'b0;
        state_nxt.level  = LVL_PML4;
        result.phys_addr = {item.entry_data[51:21], state.vaddr[20:0]};
        result.page_size = PAGE_2M;
      end else if (state.level == LVL_PT) begin
        state_nxt.busy   = 1'b0;
        state_nxt.level  = LVL_PML4;
        result.phys_addr = {item.entry_data[51:12], state.vaddr[11:0]};
        result.page_size = PAGE_4K;
      end else begin
        state_nxt.level  = req_level;
        result.kind      = KIND_REQ;
        result.read_addr = req_addr;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/four_level_page_table_walker_top.sv
// Top level of the four-level page table walker: input register, walk step
// logic, walk state and result register. Depends on ptw_pkg, ptw_cfg, ptw_step.
// Path: an input item is held in the input register, passes the walk step, and
// its result, if any, is held in the result register until it is transferred.
// Throughput: one item per cycle while the output is not stalled; the single walk
// step between the input register and the result register sets this figure.
// Reset (synchronous, active low) empties both registers and clears the walk
// state and the configuration registers to zero.
`default_nettype none
module four_level_page_table_walker_top
  import ptw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_index,
  input  wire logic [DataWidth-1:0] cfg_wdata
);

  cfg_regs_t   regs;
  in_item_t    in_item_r;
  logic        in_full_r;
  logic        in_full_nxt;
  walk_state_t state_r;
  walk_state_t state_nxt;
  out_item_t   out_item_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   step_result;
  logic        step_emit;
  logic        advance;
  logic        in_xfer;

  ptw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  ptw_step u_step (
    .item      (in_item_r),
    .state     (state_r),
    .regs      (regs),
    .state_nxt (state_nxt),
    .emit      (step_emit),
    .result    (step_result)
  );

  assign advance       = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall      = in_full_r && !advance;
  assign in_xfer       = in_valid && !in_stall;
  assign in_full_nxt   = in_xfer || (in_full_r && !advance);
  assign out_valid_nxt = (advance && step_emit) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_item;
    end
    if (advance && step_emit) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

### rtl/ptw_checker.sv
// Port-level checker for the page table walker and its bind to the top level.
// Depends on ptw_pkg and four_level_page_table_walker_top.
`default_nettype none
module ptw_checker
  import ptw_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input out_item_t out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("Stalled result changed.");

  a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_REQ |->
      out_item.phys_addr == '0 && !out_item.page_fault && out_item.page_size == PAGE_4K)
    else $error("Read request carries translation fields.");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_DONE |->
      out_item.read_addr == '0 && out_item.page_size != 2'd3)
    else $error("Finished result malformed.");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.page_fault |->
      out_item.phys_addr == '0 && out_item.page_size == PAGE_4K)
    else $error("Fault result carries an address.");

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (.*);
`default_nettype wire

### tb/tb_four_level_page_table_walker_top.sv
// Self-checking testbench for four_level_page_table_walker_top. It depends on ptw_pkg and the
// walker RTL. An in-bench model of the walk predicts every result, and a scoreboard
// checks each output transfer against it while both channels idle and stall at random.
module tb_four_level_page_table_walker_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ptw_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_wr_en;
  logic                 cfg_index;
  logic [DataWidth-1:0] cfg_wdata;

  logic [DataWidth-1:0] root_reg = '0;
  logic [DataWidth-1:0] base_reg = '0;
  logic                 walk_on  = 1'b0;
  level_t               walk_lvl = LVL_PML4;
  logic [VaWidth-1:0]   walk_va  = '0;
  out_item_t            walk_results_due[$];

  int          errors       = 0;
  int          results_sent = 0;
  int          burst_left   = 0;
  bit          gap_on       = 1'b0;
  bit          stall_on     = 1'b0;
  logic [15:0] stall_pat    = '0;
  logic [4:0]  stall_tick   = '0;

  four_level_page_table_walker_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] entry_addr(input logic [63:0] ptr, input level_t lvl);
    logic [8:0] idx;
    idx = 9'(walk_va >> (39 - 9 * int'(lvl)));
    return base_reg + {12'd0, ptr[51:12], 12'd0} + {52'd0, idx, 3'd0};
  endfunction

  function automatic bit advance_walk(input in_item_t it, output out_item_t res);
    logic [63:0] ent;
    ent = it.entry_data;
    res = '0;
    if (it.operation == OP_START) begin
      if (walk_on) return 1'b0;
      walk_on  = 1'b1;
      walk_lvl = LVL_PML4;
      walk_va  = it.virt_addr;
      res.kind      = KIND_REQ;
      res.read_addr = entry_addr(root_reg, LVL_PML4);
      return 1'b1;
    end
    if (!walk_on) return 1'b0;
    res.kind = KIND_DONE;
    if (!ent[PresentBit]) begin
      res.page_fault = 1'b1;
    end else if (walk_lvl == LVL_PDPT && ent[LargeBit]) begin
      res.phys_addr = {ent[51:30], walk_va[29:0]};
      res.page_size = PAGE_1G;
    end else if (walk_lvl == LVL_PD && ent[LargeBit]) begin
      res.phys_addr = {ent[51:21], walk_va[20:0]};
      res.page_size = PAGE_2M;
    end else if (walk_lvl == LVL_PT) begin
      res.phys_addr = {ent[51:12], walk_va[11:0]};
      res.page_size = PAGE_4K;
    end else begin
      walk_lvl      = level_t'(walk_lvl + 2'd1);
      res.kind      = KIND_REQ;
      res.read_addr = entry_addr(ent, walk_lvl);
      return 1'b1;
    end
    walk_on  = 1'b0;
    walk_lvl = LVL_PML4;
    return 1'b1;
  endfunction

  task automatic send_item(input in_item_t it);
    out_item_t res;
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (advance_walk(it, res)) begin
      walk_results_due.push_back(res);
      results_sent++;
    end
    @(negedge clk);
    if (gap_on) begin
      if (burst_left == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(0, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_start(input logic [VaWidth-1:0] va);
    in_item_t it;
    it.operation  = OP_START;
    it.virt_addr  = va;
    it.entry_data = rand64();
    send_item(it);
  endtask

  task automatic send_entry(input logic [DataWidth-1:0] data);
    in_item_t it;
    it.operation  = OP_ENTRY;
    it.virt_addr  = VaWidth'(rand64());
    it.entry_data = data;
    send_item(it);
  endtask

  function automatic logic [63:0] make_entry(input bit present, input bit big_page);
    logic [63:0] e;
    e = rand64();
    e[PresentBit] = present;
    e[LargeBit]   = big_page;
    return e;
  endfunction

  task automatic write_reg(input logic idx, input logic [DataWidth-1:0] val);
    in_valid  = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    if (idx == CFG_TABLE_ROOT) root_reg = val;
    else base_reg = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_walk();
    logic [VaWidth-1:0] va;
    case ($urandom_range(7))
      0: va = '0;
      1: va = '1;
      default: va = VaWidth'(rand64());
    endcase
    send_start(va);
    while (walk_on) begin
      if ($urandom_range(19) == 0) send_start(VaWidth'(rand64()));
      send_entry(make_entry($urandom_range(99) < 92, $urandom_range(99) < 35));
    end
  endtask

  task automatic test_directed();
    gap_on   = 1'b0;
    stall_on = 1'b0;
    write_reg(CFG_TABLE_ROOT, '1);
    write_reg(CFG_MAP_BASE, '1);
    send_entry('1);
    send_start('1);
    send_start('0);
    send_entry(64'h0000_0000_0000_0081);
    send_entry(64'h0000_0000_0000_0001);
    send_entry(64'h0000_0000_0000_0001);
    send_entry('1);
    send_start('0);
    send_entry('1);
    send_entry('1);
    send_start(48'h8000_0000_0000);
    send_entry(64'h000F_FFFF_FFFF_F001);
    send_entry(64'h0000_0000_0000_0001);
    send_entry('1);
    send_start(VaWidth'(rand64()));
    send_entry('0);
    send_start('1);
    send_entry(64'h0000_0000_0000_0001);
    send_entry(64'h0000_0000_0000_0001);
    send_entry(64'h0000_0000_0000_0001);
    send_entry(~64'h1);
    drain();
  endtask

  task automatic test_config_extremes();
    gap_on   = 1'b1;
    stall_on = 1'b1;
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_TABLE_ROOT, k[0] ? '1 : '0);
      write_reg(CFG_MAP_BASE, k[1] ? '1 : '0);
      repeat (10) run_walk();
      drain();
    end
  endtask

  task automatic test_random_walks();
    in_item_t it;
    int       target;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_TABLE_ROOT, (phase == 0) ? '0 : rand64());
      write_reg(CFG_MAP_BASE, (phase == 1) ? '1 : rand64());
      gap_on   = (phase % 3) != 0;
      stall_on = (phase % 4) != 1;
      target   = results_sent + 170;
      while (results_sent < target) begin
        if ($urandom_range(99) < 85) begin
          run_walk();
        end else begin
          it.operation  = 1'($urandom_range(1));
          it.virt_addr  = VaWidth'(rand64());
          it.entry_data = rand64();
          send_item(it);
        end
      end
      drain();
    end
  endtask

  always @(negedge clk) begin
    stall_tick = stall_tick + 1'b1;
    if (stall_tick == '0) begin
      stall_pat = 16'($urandom);
      if ($urandom_range(3) != 0) stall_pat = stall_pat & 16'($urandom);
    end
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    out_stall = stall_on && stall_pat[0];
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (walk_results_due.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_item);
        errors++;
      end else begin
        want = walk_results_due.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_item.kind));
        check_field("read_addr", want.read_addr, out_item.read_addr);
        check_field("phys_addr", 64'(want.phys_addr), 64'(out_item.phys_addr));
        check_field("page_fault", 64'(want.page_fault), 64'(out_item.page_fault));
        check_field("page_size", 64'(want.page_size), 64'(out_item.page_size));
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_TABLE_ROOT;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_extremes();
    test_random_walks();
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
